@@ sv/arpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arpc_pkg: shared types and constants of the ARP cache table
// Field widths, result status codes, table entry layout and compare result.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int ENTRIES_DEF   = 8;
    localparam int IP_W          = 32;
    localparam int MAC_W         = 48;
    localparam int TIME_W        = 16;
    localparam int IDX_W         = 4;
    localparam int STATUS_W      = 3;

    typedef logic [IP_W-1:0]   t_ip;
    typedef logic [MAC_W-1:0]  t_mac;
    typedef logic [TIME_W-1:0] t_time;
    typedef logic [IDX_W-1:0]  t_idx;

    localparam t_time REFRESH_RESET = 16'h00FF;
    localparam t_mac  MAC_BCAST     = {MAC_W{1'b1}};

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_REFRESHED = 3'd0,
        ST_ADDED     = 3'd1,
        ST_FULL      = 3'd2,
        ST_HIT       = 3'd3,
        ST_MISS      = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    // one table entry as stored in memory
    typedef struct packed {
        t_ip   ip;
        t_mac  mac;
        t_time tm;
    } t_entry;

    // compare unit verdict for one entry
    typedef struct packed {
        logic match;
        logic free;
    } t_cmp_res;

endpackage
`default_nettype wire

@@ sv/arp_cache_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
// An input transfer starts a walk in S_SCAN; S_DONE then registers the result.
// The walk reads one table word per cycle; a new item waits for the walk to end.
// o_in_ready is high only while the sequencer idles; a pending result does
//   not block a new transfer unless it is still held when the next one ends.
// Reset (synchronous, active low) clears all entry valid bits at once, so the
//   table reads as empty; refresh_time returns to 255.
// ----------------------------------------------------------------------------
// arp_cache_table: IPv4 to MAC address resolution cache
// Walks all entries with a shared compare unit, then adds, refreshes, reports
// a full table or reports a lookup result.
// ----------------------------------------------------------------------------
module arp_cache_table #(
    parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire arpc_pkg::t_time    i_cfg_data,
    // input items
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_cmd,
    input  wire arpc_pkg::t_ip      i_ip_addr,
    input  wire arpc_pkg::t_mac     i_mac_addr,
    // result items
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [arpc_pkg::STATUS_W-1:0] o_status,
    output arpc_pkg::t_idx          o_entry_index,
    output arpc_pkg::t_mac          o_dest_mac,
    output arpc_pkg::t_time         o_entry_time
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] LP_CNT_END = CW'(ENTRIES);
    localparam arpc_pkg::t_idx LP_NONE_IDX = arpc_pkg::t_idx'(ENTRIES);

    arpc_pkg::t_state   r_state, n_state;
    logic [CW-1:0]      r_cnt;
    logic               r_cmp_vld;
    logic [IW-1:0]      r_cmp_idx;
    logic               r_cmp_ent_vld;
    logic [ENTRIES-1:0] r_valid;

    logic               r_cmd;
    arpc_pkg::t_ip      r_ip;
    arpc_pkg::t_mac     r_mac;
    arpc_pkg::t_time    r_refresh;

    logic               r_hit_found;
    logic [IW-1:0]      r_hit_idx;
    arpc_pkg::t_mac     r_hit_mac;
    arpc_pkg::t_time    r_hit_time;
    logic               r_free_found;
    logic [IW-1:0]      r_free_idx;

    logic               r_out_valid;
    arpc_pkg::t_status  r_out_status;
    arpc_pkg::t_idx     r_out_idx;
    arpc_pkg::t_mac     r_out_mac;
    arpc_pkg::t_time    r_out_time;

    arpc_pkg::t_entry   w_rdata;
    arpc_pkg::t_entry   w_entry;
    arpc_pkg::t_cmp_res w_cmp;
    arpc_pkg::t_entry   w_wdata;
    logic [IW-1:0]      w_waddr;
    logic               w_we;
    logic               w_go;
    logic               w_in_xfer;
    logic               w_scan_end;
    arpc_pkg::t_status  w_res_status;
    arpc_pkg::t_idx     w_res_idx;
    arpc_pkg::t_mac     w_res_mac;
    arpc_pkg::t_time    w_res_time;

    arpc_ram #(
        .WIDTH ($bits(arpc_pkg::t_entry)),
        .DEPTH (ENTRIES),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_cnt[IW-1:0]),
        .o_rdata (w_rdata)
    );

    arpc_cmp u_cmp (
        .i_entry     (w_rdata),
        .i_entry_vld (r_cmp_ent_vld),
        .i_key       (r_ip),
        .o_entry     (w_entry),
        .o_res       (w_cmp)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == arpc_pkg::S_IDLE);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_scan_end  = (r_cnt == LP_CNT_END) && !r_cmp_vld;
    assign w_go        = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            arpc_pkg::S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = arpc_pkg::S_SCAN;
                end
            end
            arpc_pkg::S_SCAN: begin
                if (w_scan_end) begin
                    n_state = arpc_pkg::S_DONE;
                end
            end
            arpc_pkg::S_DONE: begin
                if (w_go) begin
                    n_state = arpc_pkg::S_IDLE;
                end
            end
            default: n_state = arpc_pkg::S_IDLE;
        endcase
    end

    // decide the result and the table update once the walk is over
    always_comb begin
        w_res_status = arpc_pkg::ST_FULL;
        w_res_idx    = LP_NONE_IDX;
        w_res_mac    = '0;
        w_res_time   = '0;
        w_wdata.ip   = r_ip;
        w_wdata.mac  = r_mac;
        w_wdata.tm   = r_refresh;
        w_waddr      = r_free_idx;
        w_we         = 1'b0;
        if (r_cmd == arpc_pkg::CMD_LOOKUP) begin
            if (r_hit_found) begin
                w_res_status = arpc_pkg::ST_HIT;
                w_res_idx    = arpc_pkg::t_idx'(r_hit_idx);
                w_res_mac    = r_hit_mac;
                w_res_time   = r_hit_time;
            end else begin
                w_res_status = arpc_pkg::ST_MISS;
                w_res_mac    = arpc_pkg::MAC_BCAST;
            end
        end else if (r_hit_found) begin
            // refresh: keep the stored MAC, rewrite the time
            w_res_status = arpc_pkg::ST_REFRESHED;
            w_res_idx    = arpc_pkg::t_idx'(r_hit_idx);
            w_res_time   = r_refresh;
            w_wdata.mac  = r_hit_mac;
            w_waddr      = r_hit_idx;
            w_we         = (r_state == arpc_pkg::S_DONE) && w_go;
        end else if (r_free_found) begin
            w_res_status = arpc_pkg::ST_ADDED;
            w_res_idx    = arpc_pkg::t_idx'(r_free_idx);
            w_res_time   = r_refresh;
            w_we         = (r_state == arpc_pkg::S_DONE) && w_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= arpc_pkg::S_IDLE;
            r_cmp_vld   <= 1'b0;
            r_valid     <= '0;
            r_refresh   <= arpc_pkg::REFRESH_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                r_refresh <= i_cfg_data;
            end

            if (w_we) begin
                r_valid[w_waddr] <= 1'b1;
            end

            // issue one table read per cycle during the walk
            if (r_state == arpc_pkg::S_SCAN && r_cnt != LP_CNT_END) begin
                r_cmp_vld <= 1'b1;
            end else begin
                r_cmp_vld <= 1'b0;
            end

            if (r_state == arpc_pkg::S_DONE && w_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_cmd        <= i_cmd;
            r_ip         <= i_ip_addr;
            r_mac        <= i_mac_addr;
            r_cnt        <= '0;
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            if (r_state == arpc_pkg::S_SCAN && r_cnt != LP_CNT_END) begin
                r_cmp_idx     <= r_cnt[IW-1:0];
                r_cmp_ent_vld <= r_valid[r_cnt[IW-1:0]];
                r_cnt         <= r_cnt + 1'b1;
            end
            // keep the lowest-indexed match and free entry
            if (r_cmp_vld) begin
                if (w_cmp.match && !r_hit_found) begin
                    r_hit_found <= 1'b1;
                    r_hit_idx   <= r_cmp_idx;
                    r_hit_mac   <= w_entry.mac;
                    r_hit_time  <= w_entry.tm;
                end
                if (w_cmp.free && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_cmp_idx;
                end
            end
        end

        if (r_state == arpc_pkg::S_DONE && w_go) begin
            r_out_status <= w_res_status;
            r_out_idx    <= w_res_idx;
            r_out_mac    <= w_res_mac;
            r_out_time   <= w_res_time;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_entry_index = r_out_idx;
    assign o_dest_mac    = r_out_mac;
    assign o_entry_time  = r_out_time;

endmodule
`default_nettype wire

@@ sv/arpc_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arpc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ sv/arpc_cmp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arpc_cmp: entry compare unit
// Masks an entry that was never written to all zero, then checks it against
// the key and against the free marker (IP of zero).
// ----------------------------------------------------------------------------
module arpc_cmp (
    input  wire arpc_pkg::t_entry   i_entry,
    input  wire logic               i_entry_vld,
    input  wire arpc_pkg::t_ip      i_key,
    output arpc_pkg::t_entry        o_entry,
    output arpc_pkg::t_cmp_res      o_res
);

    always_comb begin
        o_entry = i_entry_vld ? i_entry : '0;
        o_res.match = (o_entry.ip == i_key);
        o_res.free  = (o_entry.ip == '0);
    end

endmodule
`default_nettype wire

@@ sv/arpc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arpc_checker: port-level checks of the ARP cache table
// Watches the handshakes and result fields of the top level.
// ----------------------------------------------------------------------------
module arpc_checker #(
    parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_ready,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [arpc_pkg::STATUS_W-1:0] o_status,
    input wire arpc_pkg::t_idx                o_entry_index,
    input wire arpc_pkg::t_mac                o_dest_mac,
    input wire arpc_pkg::t_time               o_entry_time
);

    localparam arpc_pkg::t_idx LP_NONE_IDX = arpc_pkg::t_idx'(ENTRIES);

    // a held result stays valid with a stable status until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_status)))
        else $error("result dropped or changed while stalled");

    // each input transfer starts a walk, so ready drops right after it
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while a walk is in progress");

    a_miss_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == arpc_pkg::ST_MISS) |->
        (o_dest_mac == arpc_pkg::MAC_BCAST && o_entry_time == '0
         && o_entry_index == LP_NONE_IDX))
        else $error("lookup miss with wrong fields");

    a_add_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == arpc_pkg::ST_REFRESHED
                         || o_status == arpc_pkg::ST_ADDED
                         || o_status == arpc_pkg::ST_FULL)) |->
        (o_dest_mac == '0
         && (o_status != arpc_pkg::ST_FULL
             || (o_entry_index == LP_NONE_IDX && o_entry_time == '0))))
        else $error("add result with wrong fields");

endmodule

bind arp_cache_table arpc_checker #(
    .ENTRIES (ENTRIES)
) u_arpc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_entry_index (o_entry_index),
    .o_dest_mac    (o_dest_mac),
    .o_entry_time  (o_entry_time)
);
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for arp_cache_table
// Streams add and lookup requests through the valid/ready input channel and
// checks every result field against a cycle-free model of the cache table.
// A directed pass fills the table through its corner cases. Random phases at
// several refresh_time settings then mix hits, refreshes, misses and full
// reports under random idling on both channels, but for one phase without idling.
// ----------------------------------------------------------------------------
module tb;

    localparam int ENTRIES     = arpc_pkg::ENTRIES_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_PHASES = 5;
    localparam int PHASE_ITEMS = 126;

    typedef struct packed {
        logic          cmd;
        arpc_pkg::t_ip  ip;
        arpc_pkg::t_mac mac;
    } t_arp_req;

    typedef struct packed {
        arpc_pkg::t_status st;
        arpc_pkg::t_idx    idx;
        arpc_pkg::t_mac    mac;
        arpc_pkg::t_time   tm;
    } t_cache_reply;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            cfg_valid = 1'b0;
    arpc_pkg::t_time cfg_data  = '0;
    logic            in_valid  = 1'b0;
    logic            cmd       = arpc_pkg::CMD_ADD;
    arpc_pkg::t_ip   ip_addr   = '0;
    arpc_pkg::t_mac  mac_addr  = '0;
    logic            out_ready = 1'b0;
    logic            calm      = 1'b0;

    wire             cfg_ready;
    wire             in_ready;
    wire             out_valid;
    wire [2:0]       status;
    arpc_pkg::t_idx  entry_index;
    arpc_pkg::t_mac  dest_mac;
    arpc_pkg::t_time entry_time;

    // cache shadow and its refresh setting
    arpc_pkg::t_ip   tbl_ip   [ENTRIES];
    arpc_pkg::t_mac  tbl_mac  [ENTRIES];
    arpc_pkg::t_time tbl_time [ENTRIES];
    arpc_pkg::t_time refresh_now = arpc_pkg::REFRESH_RESET;

    t_arp_req     req_queue[$];
    t_cache_reply replies_due[$];
    t_arp_req     cur_req;
    int           err_count   = 0;
    int           cycles      = 0;
    int           cfg_writes  = 0;
    int           seen_status [5];

    arp_cache_table #(
        .ENTRIES(ENTRIES)
    ) i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_cmd        (cmd),
        .i_ip_addr    (ip_addr),
        .i_mac_addr   (mac_addr),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_status     (status),
        .o_entry_index(entry_index),
        .o_dest_mac   (dest_mac),
        .o_entry_time (entry_time)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    function automatic int first_slot(input arpc_pkg::t_ip ip);
        for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_ip[i] == ip) begin
                return i;
            end
        end
        return ENTRIES;
    endfunction

    // apply one request to the shadow table and return the result it gives
    function automatic t_cache_reply resolve_request(input t_arp_req rq);
        t_cache_reply r;
        int slot;
        r.mac = '0;
        r.tm  = '0;
        slot  = first_slot(rq.ip);
        if (rq.cmd == arpc_pkg::CMD_LOOKUP) begin
            if (slot < ENTRIES) begin
                r.st  = arpc_pkg::ST_HIT;
                r.idx = arpc_pkg::t_idx'(slot);
                r.mac = tbl_mac[slot];
                r.tm  = tbl_time[slot];
            end else begin
                r.st  = arpc_pkg::ST_MISS;
                r.idx = arpc_pkg::t_idx'(ENTRIES);
                r.mac = arpc_pkg::MAC_BCAST;
            end
        end else if (slot < ENTRIES) begin
            tbl_time[slot] = refresh_now;
            r.st  = arpc_pkg::ST_REFRESHED;
            r.idx = arpc_pkg::t_idx'(slot);
            r.tm  = refresh_now;
        end else begin
            // a zero IP always matches above while a free entry remains
            slot = first_slot('0);
            if (slot < ENTRIES) begin
                tbl_ip[slot]   = rq.ip;
                tbl_mac[slot]  = rq.mac;
                tbl_time[slot] = refresh_now;
                r.st  = arpc_pkg::ST_ADDED;
                r.idx = arpc_pkg::t_idx'(slot);
                r.tm  = refresh_now;
            end else begin
                r.st  = arpc_pkg::ST_FULL;
                r.idx = arpc_pkg::t_idx'(ENTRIES);
            end
        end
        return r;
    endfunction

    function automatic arpc_pkg::t_mac rand_mac();
        return {16'($urandom_range(16'hFFFF, 0)), 32'($urandom())};
    endfunction

    function automatic t_arp_req make_req(input logic c, input arpc_pkg::t_ip ip,
                                          input arpc_pkg::t_mac mac);
        t_arp_req rq;
        rq.cmd = c;
        rq.ip  = ip;
        rq.mac = mac;
        return rq;
    endfunction

    // random request biased toward addresses the table holds
    function automatic t_arp_req rand_req();
        arpc_pkg::t_ip ip;
        int            pick;
        pick = $urandom_range(99);
        if (pick < 45) begin
            ip = tbl_ip[$urandom_range(ENTRIES - 1)];
        end else if (pick < 55) begin
            ip = '0;
        end else if (pick < 65) begin
            ip = tbl_ip[$urandom_range(ENTRIES - 1)]
                 ^ (arpc_pkg::t_ip'(1) << $urandom_range(31));
        end else begin
            ip = $urandom();
        end
        return make_req(1'($urandom_range(1)), ip, rand_mac());
    endfunction

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[%0t] timeout with %0d results outstanding", $realtime,
                     replies_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // request driver: hold each transfer until accepted, idle at random between
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                replies_due.push_back(resolve_request(cur_req));
            end
            if (!in_valid || in_ready) begin
                if (req_queue.size() > 0 && (calm || $urandom_range(99) >= 38)) begin
                    cur_req  = req_queue.pop_front();
                    in_valid <= 1'b1;
                    cmd      <= cur_req.cmd;
                    ip_addr  <= cur_req.ip;
                    mac_addr <= cur_req.mac;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random backpressure
    always @(posedge clk) begin
        t_cache_reply want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (replies_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result status %0d index %0d",
                                              status, entry_index));
                end else begin
                    want = replies_due.pop_front();
                    seen_status[want.st]++;
                    if (status !== want.st)
                        report_mismatch($sformatf("status %0d, want %0d", status, want.st));
                    if (entry_index !== want.idx)
                        report_mismatch($sformatf("entry_index %0d, want %0d",
                                                  entry_index, want.idx));
                    if (dest_mac !== want.mac)
                        report_mismatch($sformatf("dest_mac %h, want %h", dest_mac, want.mac));
                    if (entry_time !== want.tm)
                        report_mismatch($sformatf("entry_time %h, want %h",
                                                  entry_time, want.tm));
                end
            end
            out_ready <= calm || ($urandom_range(99) >= 38);
        end
    end

    task automatic wait_drained();
        while (req_queue.size() != 0 || in_valid || replies_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_refresh(input arpc_pkg::t_time value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        refresh_now = value;
        cfg_writes++;
        cfg_valid <= 1'b0;
    endtask

    initial begin
        arpc_pkg::t_time phase_refresh;
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_ip[i]   = '0;
            tbl_mac[i]  = '0;
            tbl_time[i] = '0;
        end
        for (int i = 0; i < 5; i++) seen_status[i] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pass at the reset refresh_time: empty table, zero IP, fill, full
        req_queue.push_back(make_req(arpc_pkg::CMD_LOOKUP, 32'h0A00_0001, 48'h0));
        req_queue.push_back(make_req(arpc_pkg::CMD_LOOKUP, 32'h0, 48'h0));
        req_queue.push_back(make_req(arpc_pkg::CMD_ADD,    32'h0, arpc_pkg::MAC_BCAST));
        req_queue.push_back(make_req(arpc_pkg::CMD_LOOKUP, 32'h0, 48'h0));
        req_queue.push_back(make_req(arpc_pkg::CMD_ADD,    32'hFFFF_FFFF,
                                     arpc_pkg::MAC_BCAST));
        req_queue.push_back(make_req(arpc_pkg::CMD_ADD,    32'h0000_0001,
                                     48'h0000_0000_0001));
        req_queue.push_back(make_req(arpc_pkg::CMD_ADD,    32'h8000_0000,
                                     48'h8000_0000_0000));
        req_queue.push_back(make_req(arpc_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 48'h0));
        req_queue.push_back(make_req(arpc_pkg::CMD_LOOKUP, 32'h0000_0001,
                                     arpc_pkg::MAC_BCAST));
        req_queue.push_back(make_req(arpc_pkg::CMD_ADD,    32'hFFFF_FFFF, 48'h0));
        req_queue.push_back(make_req(arpc_pkg::CMD_LOOKUP, 32'h0, 48'h0));
        req_queue.push_back(make_req(arpc_pkg::CMD_LOOKUP, 32'h7FFF_FFFF,
                                     48'hFFFF_0000_FFFF));
        req_queue.push_back(make_req(arpc_pkg::CMD_ADD,    32'h7FFF_FFFF,
                                     48'h7FFF_FFFF_FFFF));
        req_queue.push_back(make_req(arpc_pkg::CMD_ADD,    32'hAAAA_AAAA,
                                     48'hAAAA_AAAA_AAAA));
        req_queue.push_back(make_req(arpc_pkg::CMD_ADD,    32'h5555_5555,
                                     48'h5555_5555_5555));
        req_queue.push_back(make_req(arpc_pkg::CMD_ADD,    32'hC0A8_0001,
                                     48'h0123_4567_89AB));
        req_queue.push_back(make_req(arpc_pkg::CMD_ADD,    32'h0A00_0002,
                                     48'hFEDC_BA98_7654));
        req_queue.push_back(make_req(arpc_pkg::CMD_ADD,    32'h0, 48'h1111_2222_3333));
        req_queue.push_back(make_req(arpc_pkg::CMD_LOOKUP, 32'h0, 48'h0));
        req_queue.push_back(make_req(arpc_pkg::CMD_ADD,    32'h1234_5678,
                                     48'hABCD_EF01_2345));
        req_queue.push_back(make_req(arpc_pkg::CMD_LOOKUP, 32'h0A00_0002, 48'h0));
        req_queue.push_back(make_req(arpc_pkg::CMD_ADD,    32'h5555_5555, 48'h0));
        req_queue.push_back(make_req(arpc_pkg::CMD_LOOKUP, 32'h1234_5678, 48'h0));

        // random phases, each at its own refresh_time, extremes first
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: phase_refresh = 16'h0000;
                1: phase_refresh = 16'hFFFF;
                default: phase_refresh = arpc_pkg::t_time'($urandom_range(16'hFFFF, 0));
            endcase
            write_refresh(phase_refresh);
            // run one phase without any idling on either side
            calm = (p == 1);
            for (int i = 0; i < PHASE_ITEMS; i++) req_queue.push_back(rand_req());
        end

        wait_drained();
        calm = 1'b0;
        repeat (4 * (ENTRIES + 4)) @(posedge clk);

        $display("Covered %0d refreshed, %0d added, %0d full, %0d hits, %0d misses",
                 seen_status[arpc_pkg::ST_REFRESHED], seen_status[arpc_pkg::ST_ADDED],
                 seen_status[arpc_pkg::ST_FULL], seen_status[arpc_pkg::ST_HIT],
                 seen_status[arpc_pkg::ST_MISS]);
        $display("over %0d refresh_time writes, %0d mismatches", cfg_writes, err_count);
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
